// ----- hw/rtl/bckl_pkg.sv -----
// ----------------------------------------------------------------------------
// bckl_pkg
// Shared types and codes for the bounded compacting key list.
// ----------------------------------------------------------------------------
`default_nettype none

package bckl_pkg;

  // default sizing
  localparam int MAX_ENTRIES_DEF      = 16;
  localparam int INITIAL_CAPACITY_DEF = 5;

  // fixed field widths
  localparam int ACT_W    = 3;
  localparam int HANDLE_W = 16;
  localparam int PKEY_W   = 44;
  localparam int TKEY_W   = 64;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 3;
  localparam int CNT_OUT_W = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GROW   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SHRINK = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_LIMIT     = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;

  // one stored entry
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PKEY_W-1:0]   pkey;
    logic [TKEY_W-1:0]   tkey;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    entry_t           data;     // new entry / keys to match
    logic [POS_W-1:0] pos;
    logic             find;     // select match uses title key, else position
    logic             capture;  // register match flags this cycle
    logic             append;   // write data into the cell at the tail
    logic             remove;   // compact after the first key hit
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bounded_compacting_key_list.sv -----
// ----------------------------------------------------------------------------
// bounded_compacting_key_list
// Insertion-ordered entry list with append, remove-and-compact, capacity
// grow/shrink, find by title key and read by position.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (action, handle, primary_key, title_key, position) enter on
//   in_valid/in_ready; one result word (status, found_handle, entry_count,
//   capacity_now) leaves on out_valid/out_ready for every input word.
//   Entries live in a row of cells, one per slot. Each command runs through
//   S_CMP and S_EXEC: in S_CMP every cell compares its entry against the
//   broadcast keys and registers the match, in S_EXEC the first match is
//   resolved along the row, the list is updated (a removal shifts every
//   later cell down by one in that same cycle) and the result is loaded into
//   the output register. A new word is accepted only in S_IDLE or as the
//   previous command leaves S_EXEC, never while one is in S_CMP.
//   The output register decouples the sides: a new word is accepted while a
//   result is still waiting. If the receiver stalls and the output register
//   is occupied, the finished command holds in its execute cycle and
//   in_ready stays low until the result can be loaded.
//   Reset empties the list and sets capacity to INITIAL_CAPACITY (limited to
//   MAX_ENTRIES); entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_compacting_key_list #(
  parameter int MAX_ENTRIES      = bckl_pkg::MAX_ENTRIES_DEF,
  parameter int INITIAL_CAPACITY = bckl_pkg::INITIAL_CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bckl_pkg::ACT_W-1:0]        action,
  input  wire logic [bckl_pkg::HANDLE_W-1:0]     handle,
  input  wire logic [bckl_pkg::PKEY_W-1:0]       primary_key,
  input  wire logic [bckl_pkg::TKEY_W-1:0]       title_key,
  input  wire logic [bckl_pkg::POS_W-1:0]        position,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bckl_pkg::STAT_W-1:0]            status,
  output logic [bckl_pkg::HANDLE_W-1:0]          found_handle,
  output logic [bckl_pkg::CNT_OUT_W-1:0]         entry_count,
  output logic [bckl_pkg::CNT_OUT_W-1:0]         capacity_now
);

  localparam int CW   = $clog2(MAX_ENTRIES+1);
  localparam int CMPW = (CW > bckl_pkg::POS_W) ? CW : bckl_pkg::POS_W;
  localparam int INIT_CAP = (INITIAL_CAPACITY > MAX_ENTRIES) ? MAX_ENTRIES
                                                             : INITIAL_CAPACITY;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC} state_t;

  state_t                        state;
  logic [bckl_pkg::ACT_W-1:0]    act;
  bckl_pkg::entry_t              key;
  logic [bckl_pkg::POS_W-1:0]    pos;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 cap;
  logic [CW-1:0]                 count_next;
  logic [CW-1:0]                 cap_next;
  logic [bckl_pkg::STAT_W-1:0]   status_next;
  logic [bckl_pkg::HANDLE_W-1:0] found_next;

  logic                accept;
  logic                fire;
  logic                full;
  bckl_pkg::cell_cmd_t cmd;

  bckl_pkg::entry_t              cell_data [MAX_ENTRIES];
  logic                          hit   [MAX_ENTRIES+1];
  logic                          sel   [MAX_ENTRIES+1];
  logic [bckl_pkg::HANDLE_W-1:0] sel_h [MAX_ENTRIES+1];

  // handshake
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE) || fire;
  assign accept   = in_valid && in_ready;
  assign full     = count >= cap;

  // command broadcast
  always_comb begin
    cmd.data    = key;
    cmd.pos     = pos;
    cmd.find    = act == bckl_pkg::ACT_FIND;
    cmd.capture = state == S_CMP;
    cmd.append  = fire && (act == bckl_pkg::ACT_APPEND) && !full;
    cmd.remove  = fire && (act == bckl_pkg::ACT_REMOVE) && hit[MAX_ENTRIES];
  end

  // row of cells
  assign hit[0]             = 1'b0;
  assign sel[MAX_ENTRIES]   = 1'b0;
  assign sel_h[MAX_ENTRIES] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    bckl_pkg::entry_t right;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    bckl_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (i)
    ) u_cell (
      .clk            (clk),
      .cmd            (cmd),
      .count          (count),
      .right_data     (right),
      .data           (cell_data[i]),
      .hit_in         (hit[i]),
      .hit_out        (hit[i+1]),
      .sel_in         (sel[i+1]),
      .sel_handle_in  (sel_h[i+1]),
      .sel_out        (sel[i]),
      .sel_handle_out (sel_h[i])
    );
  end

  // result and next list size
  always_comb begin
    count_next  = count;
    cap_next    = cap;
    status_next = bckl_pkg::ST_OK;
    found_next  = '0;
    case (act)
      bckl_pkg::ACT_APPEND: begin
        if (full) begin
          status_next = bckl_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      bckl_pkg::ACT_REMOVE: begin
        if (hit[MAX_ENTRIES]) begin
          count_next = count - 1'b1;
        end else begin
          status_next = bckl_pkg::ST_NOT_FOUND;
        end
      end
      bckl_pkg::ACT_GROW: begin
        if (cap >= CW'(MAX_ENTRIES)) begin
          status_next = bckl_pkg::ST_LIMIT;
        end else begin
          cap_next = cap + 1'b1;
        end
      end
      bckl_pkg::ACT_SHRINK: begin
        if (cap == '0) begin
          status_next = bckl_pkg::ST_LIMIT;
        end else begin
          if (count >= cap) begin
            count_next = count - 1'b1;
          end
          cap_next = cap - 1'b1;
        end
      end
      bckl_pkg::ACT_FIND: begin
        if (sel[0]) begin
          found_next = sel_h[0];
        end else begin
          status_next = bckl_pkg::ST_NOT_FOUND;
        end
      end
      bckl_pkg::ACT_READ: begin
        if (CMPW'(pos) >= CMPW'(count)) begin
          status_next = bckl_pkg::ST_BAD_POS;
        end else begin
          found_next = sel_h[0];
        end
      end
      default: begin
      end
    endcase
  end

  // command capture (payload only)
  always_ff @(posedge clk) begin
    if (accept) begin
      act    <= action;
      key    <= '{handle: handle, pkey: primary_key, tkey: title_key};
      pos    <= position;
    end
  end

  // sequencer, list size and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= CW'(INIT_CAP);
      out_valid <= 1'b0;
    end else begin
      // result word loads on fire, drops once taken
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) begin
            count        <= count_next;
            cap          <= cap_next;
            status       <= status_next;
            found_handle <= found_next;
            entry_count  <= bckl_pkg::CNT_OUT_W'(count_next);
            capacity_now <= bckl_pkg::CNT_OUT_W'(cap_next);
            state        <= accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bckl_cell.sv -----
// ----------------------------------------------------------------------------
// bckl_cell
// One list slot: holds an entry, compares it against the broadcast keys and
// takes its right neighbor's entry when the list compacts.
// ----------------------------------------------------------------------------
`default_nettype none

module bckl_cell #(
  parameter int MAX_ENTRIES = bckl_pkg::MAX_ENTRIES_DEF,
  parameter int IDX         = 0
) (
  input  wire logic                              clk,
  input  wire bckl_pkg::cell_cmd_t               cmd,
  input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]  count,
  input  wire bckl_pkg::entry_t                  right_data,
  output bckl_pkg::entry_t                       data,
  input  wire logic                              hit_in,
  output logic                                   hit_out,
  input  wire logic                              sel_in,
  input  wire logic [bckl_pkg::HANDLE_W-1:0]     sel_handle_in,
  output logic                                   sel_out,
  output logic [bckl_pkg::HANDLE_W-1:0]          sel_handle_out
);

  localparam int CW = $clog2(MAX_ENTRIES+1);
  localparam bit POS_REACH = IDX < (1 << bckl_pkg::POS_W);

  logic occ;
  logic pos_eq;
  logic pk_hit;
  logic sel_hit;

  // slot holds a live entry
  assign occ    = count > CW'(IDX);
  assign pos_eq = POS_REACH && (cmd.pos == bckl_pkg::POS_W'(IDX));

  // match flags, registered in S_CMP ahead of execution
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pk_hit  <= occ && (data.pkey == cmd.data.pkey);
      sel_hit <= occ && (cmd.find ? (data.tkey == cmd.data.tkey) : pos_eq);
    end
  end

  // first key hit propagates toward the tail
  assign hit_out = hit_in | pk_hit;

  // first selected entry propagates toward the head
  assign sel_out        = sel_hit | sel_in;
  assign sel_handle_out = sel_hit ? data.handle : sel_handle_in;

  // entry storage: tail write or shift from the right neighbor
  always_ff @(posedge clk) begin
    if (cmd.append && (count == CW'(IDX))) begin
      data <= cmd.data;
    end else if (cmd.remove && hit_out) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bckl_checker.sv -----
// ----------------------------------------------------------------------------
// bckl_checker
// Port-level checks for the bounded compacting key list, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bckl_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [bckl_pkg::STAT_W-1:0]       status,
  input wire logic [bckl_pkg::HANDLE_W-1:0]     found_handle,
  input wire logic [bckl_pkg::CNT_OUT_W-1:0]    entry_count,
  input wire logic [bckl_pkg::CNT_OUT_W-1:0]    capacity_now
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(found_handle) && $stable(entry_count) && $stable(capacity_now))
    else $error("result word changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word valid right after reset");

  // handle only reported with an ok status
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != bckl_pkg::ST_OK) |-> found_handle == '0)
    else $error("handle reported on a failed action");

  // list never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= capacity_now)
    else $error("entry count above capacity");

  // an input word is never taken back to back with the one before
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input word accepted in consecutive cycles");

endmodule

bind bounded_compacting_key_list bckl_checker u_bckl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .found_handle (found_handle),
  .entry_count  (entry_count),
  .capacity_now (capacity_now)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded compacting key list. A directed table
// walks the corner cases (empty list, zero capacity, capacity limit, full
// list, duplicate keys, compaction across the whole row, spare action codes),
// then random command words run in phases that push capacity up and down.
// Every result word is checked field by field against its table row or an in-bench
// model of the list; outside the last phase both sides get random idle bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bckl_pkg::*;

  localparam int SLOTS     = MAX_ENTRIES_DEF;
  localparam int CAP_RESET = (INITIAL_CAPACITY_DEF > SLOTS) ? SLOTS : INITIAL_CAPACITY_DEF;

  // action codes the block treats as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  localparam int RANDOM_WORDS = 2000;
  localparam int PHASES       = 4;
  localparam int KEY_POOL     = 6;
  localparam int MAX_REPORTS  = 50;

  localparam logic [PKEY_W-1:0] PK_ONES = {PKEY_W{1'b1}};
  localparam logic [TKEY_W-1:0] TK_ONES = {TKEY_W{1'b1}};

  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [HANDLE_W-1:0] hnd;
    logic [PKEY_W-1:0]   pkey;
    logic [TKEY_W-1:0]   tkey;
    logic [POS_W-1:0]    pos;
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [HANDLE_W-1:0]  handle;
    logic [CNT_OUT_W-1:0] held;
    logic [CNT_OUT_W-1:0] cap;
  } list_resp_t;

  localparam list_resp_t UNTYPED = '0;

  typedef struct {
    list_cmd_t  cmd;
    int         reps;
    bit         typed;
    list_resp_t want;
  } dir_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [ACT_W-1:0]     action      = '0;
  logic [HANDLE_W-1:0]  handle      = '0;
  logic [PKEY_W-1:0]    primary_key = '0;
  logic [TKEY_W-1:0]    title_key   = '0;
  logic [POS_W-1:0]     position    = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [STAT_W-1:0]    status;
  logic [HANDLE_W-1:0]  found_handle;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [CNT_OUT_W-1:0] capacity_now;

  bounded_compacting_key_list u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .handle       (handle),
    .primary_key  (primary_key),
    .title_key    (title_key),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_handle (found_handle),
    .entry_count  (entry_count),
    .capacity_now (capacity_now)
  );

  // shadow copy of the list
  logic [HANDLE_W-1:0]  list_handle [SLOTS];
  logic [PKEY_W-1:0]    list_pkey   [SLOTS];
  logic [TKEY_W-1:0]    list_tkey   [SLOTS];
  logic [CNT_OUT_W-1:0] list_held = '0;
  logic [CNT_OUT_W-1:0] list_cap  = CAP_RESET[CNT_OUT_W-1:0];

  // keys reused so that removes and finds hit
  logic [PKEY_W-1:0] pkey_pool [KEY_POOL];
  logic [TKEY_W-1:0] tkey_pool [KEY_POOL];

  list_resp_t due_results [$];
  dir_row_t   directed_rows [$];

  int err_count     = 0;
  int words_sent    = 0;
  int dir_words     = 0;
  int results_seen  = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_hold     = 0;
  int status_tally [8];

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // apply one command to the shadow list and work out its result word
  task automatic apply_to_list(input list_cmd_t c, output list_resp_t r);
    int hit;
    hit = -1;
    r = '0;
    r.status = ST_OK;
    case (c.act)
      ACT_APPEND: begin
        if (list_held >= list_cap) begin
          r.status = ST_FULL;
        end else begin
          list_handle[int'(list_held)] = c.hnd;
          list_pkey[int'(list_held)]   = c.pkey;
          list_tkey[int'(list_held)]   = c.tkey;
          list_held++;
        end
      end
      ACT_REMOVE: begin
        for (int i = 0; i < int'(list_held); i++)
          if (hit < 0 && list_pkey[i] == c.pkey) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // close the gap behind the removed entry
          for (int i = hit; i + 1 < int'(list_held); i++) begin
            list_handle[i] = list_handle[i+1];
            list_pkey[i]   = list_pkey[i+1];
            list_tkey[i]   = list_tkey[i+1];
          end
          list_held--;
        end
      end
      ACT_GROW: begin
        if (int'(list_cap) >= SLOTS) r.status = ST_LIMIT;
        else list_cap++;
      end
      ACT_SHRINK: begin
        if (list_cap == '0) begin
          r.status = ST_LIMIT;
        end else begin
          // a full list loses its last entry
          if (list_held >= list_cap && list_held != '0) list_held--;
          list_cap--;
        end
      end
      ACT_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < int'(list_held); i++)
          if (hit < 0 && list_tkey[i] == c.tkey) hit = i;
        if (hit >= 0) begin
          r.status = ST_OK;
          r.handle = list_handle[hit];
        end
      end
      ACT_READ: begin
        if (int'(c.pos) >= int'(list_held)) r.status = ST_BAD_POS;
        else r.handle = list_handle[int'(c.pos)];
      end
      default: begin
      end
    endcase
    r.held = list_held;
    r.cap  = list_cap;
  endtask

  // random command word, keys steered toward stored entries and the pool
  function automatic list_cmd_t draw_command(input int grow_w, input int shrink_w);
    list_cmd_t   c;
    logic [63:0] r64;
    logic [31:0] r32;
    int          roll;
    int          slot;
    r32 = $urandom;
    c.hnd = r32[HANDLE_W-1:0];
    r64 = {$urandom, $urandom};
    c.pkey = r64[PKEY_W-1:0];
    r64 = {$urandom, $urandom};
    c.tkey = r64;
    r32 = $urandom;
    c.pos = r32[POS_W-1:0];

    roll = $urandom_range(0, 81 + grow_w + shrink_w);
    if (roll < 30) c.act = ACT_APPEND;
    else if (roll < 48) c.act = ACT_REMOVE;
    else if (roll < 48 + grow_w) c.act = ACT_GROW;
    else if (roll < 48 + grow_w + shrink_w) c.act = ACT_SHRINK;
    else if (roll < 63 + grow_w + shrink_w) c.act = ACT_FIND;
    else if (roll < 78 + grow_w + shrink_w) c.act = ACT_READ;
    else c.act = roll[0] ? ACT_SPARE6 : ACT_SPARE7;

    roll = $urandom_range(0, 99);
    if (roll < 45 && list_held != '0) begin
      slot = $urandom_range(0, int'(list_held) - 1);
      c.pkey = list_pkey[slot];
      c.tkey = list_tkey[slot];
    end else if (roll < 80) begin
      slot = $urandom_range(0, KEY_POOL - 1);
      c.pkey = pkey_pool[slot];
      c.tkey = tkey_pool[slot];
    end

    // mostly positions inside the list
    if ($urandom_range(0, 99) < 75 && list_held != '0) begin
      r32 = $urandom_range(0, int'(list_held) - 1);
      c.pos = r32[POS_W-1:0];
    end
    return c;
  endfunction

  // drive one command word and record what it should return
  task automatic push_word(input list_cmd_t c, input bit typed, input list_resp_t want);
    list_resp_t pred;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= c.act;
    handle      <= c.hnd;
    primary_key <= c.pkey;
    title_key   <= c.tkey;
    position    <= c.pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_list(c, pred);
    due_results.push_back(typed ? want : pred);
    words_sent++;
  endtask

  task automatic add_row(input list_cmd_t c, input int reps, input bit typed,
                         input list_resp_t want);
    dir_row_t row;
    row.cmd   = c;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // result side stalls in bursts
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      out_ready <= 1'b0;
      sink_hold <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result word with the oldest outstanding one
  always @(posedge clk) begin : check_results
    list_resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        want = due_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (found_handle !== want.handle)
          report_mismatch($sformatf("found_handle %h, want %h", found_handle, want.handle));
        if (entry_count !== want.held)
          report_mismatch($sformatf("entry_count %0d, want %0d", entry_count, want.held));
        if (capacity_now !== want.cap)
          report_mismatch($sformatf("capacity_now %0d, want %0d", capacity_now, want.cap));
        results_seen++;
        status_tally[status]++;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    list_cmd_t   c;
    logic [63:0] r64;
    int          gw;
    int          sw;

    foreach (status_tally[i]) status_tally[i] = 0;

    // empty list, zero capacity and the capacity ceiling
    add_row(list_cmd_t'{ACT_READ, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_BAD_POS, 16'h0000, 5'd0, 5'd5});
    add_row(list_cmd_t'{ACT_REMOVE, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_NOT_FOUND, 16'h0000, 5'd0, 5'd5});
    add_row(list_cmd_t'{ACT_FIND, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_NOT_FOUND, 16'h0000, 5'd0, 5'd5});
    add_row(list_cmd_t'{ACT_SHRINK, 16'h0000, 44'h0, 64'h0, 4'd0}, 5, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_SHRINK, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_LIMIT, 16'h0000, 5'd0, 5'd0});
    add_row(list_cmd_t'{ACT_APPEND, 16'h0001, 44'h1, 64'h1, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_FULL, 16'h0000, 5'd0, 5'd0});
    add_row(list_cmd_t'{ACT_SPARE6, 16'hFFFF, PK_ONES, TK_ONES, 4'hF}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'h0000, 5'd0, 5'd0});
    add_row(list_cmd_t'{ACT_GROW, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'h0000, 5'd0, 5'd1});
    add_row(list_cmd_t'{ACT_APPEND, 16'hFFFF, PK_ONES, TK_ONES, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'h0000, 5'd1, 5'd1});
    add_row(list_cmd_t'{ACT_APPEND, 16'h1234, 44'h77, 64'h77, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_FULL, 16'h0000, 5'd1, 5'd1});
    add_row(list_cmd_t'{ACT_FIND, 16'h0000, 44'h0, TK_ONES, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'hFFFF, 5'd1, 5'd1});
    add_row(list_cmd_t'{ACT_READ, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'hFFFF, 5'd1, 5'd1});
    add_row(list_cmd_t'{ACT_READ, 16'h0000, 44'h0, 64'h0, 4'hF}, 1, 1'b1,
            list_resp_t'{ST_BAD_POS, 16'h0000, 5'd1, 5'd1});
    add_row(list_cmd_t'{ACT_SPARE7, 16'hA5A5, PK_ONES, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'h0000, 5'd1, 5'd1});
    add_row(list_cmd_t'{ACT_GROW, 16'h0000, 44'h0, 64'h0, 4'd0}, 15, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_GROW, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_LIMIT, 16'h0000, 5'd1, 5'd16});
    // duplicate keys, then a remove that must take only the first
    add_row(list_cmd_t'{ACT_APPEND, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'h0000, 5'd2, 5'd16});
    add_row(list_cmd_t'{ACT_APPEND, 16'h00A5, 44'h5, 64'h5, 4'd0}, 3, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_APPEND, 16'h5A00, 44'h5, 64'h6, 4'd0}, 1, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_REMOVE, 16'h0000, 44'h5, 64'h0, 4'd0}, 1, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_FIND, 16'h0000, 44'h0, 64'h5, 4'd0}, 1, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_REMOVE, 16'h0000, 44'h123, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_NOT_FOUND, 16'h0000, 5'd5, 5'd16});
    // fill to the top, then shrink a full list and compact across the row
    add_row(list_cmd_t'{ACT_APPEND, 16'h0F0F, 44'h918_2736_455A, 64'hC3C3_0F0F_A5A5_1234,
                        4'd0}, 11, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_APPEND, 16'h4321, 44'h1, 64'h1, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_FULL, 16'h0000, 5'd16, 5'd16});
    add_row(list_cmd_t'{ACT_READ, 16'h0000, 44'h0, 64'h0, 4'hF}, 1, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_SHRINK, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b1,
            list_resp_t'{ST_OK, 16'h0000, 5'd15, 5'd15});
    add_row(list_cmd_t'{ACT_REMOVE, 16'h0000, PK_ONES, 64'h0, 4'd0}, 1, 1'b0, UNTYPED);
    add_row(list_cmd_t'{ACT_FIND, 16'h0000, 44'h0, 64'h0, 4'd0}, 1, 1'b0, UNTYPED);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    src_idle_pct  = 20;
    sink_idle_pct = 8;
    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        push_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    dir_words = words_sent;

    // random phases, each opened once the block has drained
    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (due_results.size() != 0);

      pkey_pool[0] = '0;
      tkey_pool[0] = '0;
      pkey_pool[1] = PK_ONES;
      tkey_pool[1] = TK_ONES;
      for (int k = 2; k < KEY_POOL; k++) begin
        r64 = {$urandom, $urandom};
        pkey_pool[k] = r64[PKEY_W-1:0];
        r64 = {$urandom, $urandom};
        tkey_pool[k] = r64;
      end

      case (ph)
        0:       begin gw = 8;  sw = 8;  end
        1:       begin gw = 3;  sw = 12; end
        2:       begin gw = 14; sw = 3;  end
        default: begin gw = 8;  sw = 8;  end
      endcase

      for (int k = 0; k < RANDOM_WORDS / PHASES; k++) begin
        if (k % 100 == 0) begin
          if (ph == PHASES - 1) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
          end else begin
            src_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : 25;
            sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 10;
          end
        end
        c = draw_command(gw, sw);
        push_word(c, 1'b0, UNTYPED);
      end
    end

    // drain and settle
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (8) @(posedge clk);

    $display("covered %0d command words (%0d directed), %0d result words checked",
             words_sent, dir_words, results_seen);
    $display("status mix: ok %0d, full %0d, not found %0d, limit %0d, bad position %0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_NOT_FOUND],
             status_tally[ST_LIMIT], status_tally[ST_BAD_POS]);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("watchdog expired with %0d results outstanding", due_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
